### sv/raw_color_matrix_transform_assert.svh
// ----------------------------------------------------------------------------
// raw_color_matrix_transform assertion macros
// Shared concurrent assertion forms for the color matrix checker.
// ----------------------------------------------------------------------------
`ifndef RAW_COLOR_MATRIX_TRANSFORM_ASSERT_SVH
`define RAW_COLOR_MATRIX_TRANSFORM_ASSERT_SVH

// same-cycle implication, masked during reset
`define RCMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, masked during reset
`define RCMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, always checked
`define RCMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### sv/rcmt_pkg.sv
// ----------------------------------------------------------------------------
// rcmt_pkg
// Widths, register indexes, mode codes and types for the color matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcmt_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int OUT_W        = 28;
    localparam int FRAC_DROP    = 8;
    localparam int ACC_W        = OUT_W + FRAC_DROP;
    localparam int PROD_W       = COEF_W + SAMPLE_BITS + 1;
    localparam int CFG_W        = 48;
    localparam int CFG_ADDR_W   = 2;
    localparam int MODE_W       = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 88;
    localparam int M_PAD_W      = M_TDATA_W - 3 * OUT_W;
    localparam int ROUND_BIAS   = 1 << (FRAC_DROP - 1);

    localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIAG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONO = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW0 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2 = 2'd3;

    localparam logic [CFG_W-1:0] ROW0_RST = 48'h0000_0000_1000;
    localparam logic [CFG_W-1:0] ROW1_RST = 48'h0000_1000_0000;
    localparam logic [CFG_W-1:0] ROW2_RST = 48'h1000_0000_0000;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [2:0] coef_row_t;
    typedef logic [SAMPLE_BITS-1:0] samp_t;
    typedef samp_t [2:0] pixel_t;
    typedef logic signed [OUT_W-1:0] chan_t;

endpackage

`default_nettype wire

### sv/rcmt_row.sv
// ----------------------------------------------------------------------------
// rcmt_row
// One output channel: registered products, then exact sum and round to Q.4.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmt_row (
    input  wire                       aclk,
    input  wire                       prod_en,
    input  wire                       out_en,
    input  wire rcmt_pkg::coef_row_t  coefs,
    input  wire rcmt_pkg::pixel_t     pix,
    output rcmt_pkg::chan_t           value_reg
);

    logic signed [rcmt_pkg::PROD_W-1:0] prod_reg  [3];
    logic signed [rcmt_pkg::PROD_W-1:0] prod_next [3];
    logic signed [rcmt_pkg::ACC_W-1:0]  acc;
    rcmt_pkg::chan_t                    value_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = coefs[k] * $signed({1'b0, pix[k]});
        end
    end

    always_comb begin
        acc = rcmt_pkg::ACC_W'(prod_reg[0]) + rcmt_pkg::ACC_W'(prod_reg[1])
            + rcmt_pkg::ACC_W'(prod_reg[2])
            + rcmt_pkg::ACC_W'(rcmt_pkg::ROUND_BIAS);
        value_next = acc[rcmt_pkg::ACC_W-1:rcmt_pkg::FRAC_DROP];
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (out_en) begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

### sv/raw_color_matrix_transform.sv
// Pipeline: an accepted input word passes the input, product and result
// registers before it reaches m_tvalid.
// Throughput: one pixel per cycle while the output is not stalled; the three
// stages advance independently and bubbles collapse under back-pressure.
// Reset: aresetn (sync, active low) empties the pipeline and loads the
// identity matrix in mode 0.
// ----------------------------------------------------------------------------
// raw_color_matrix_transform
// 3x3 color correction on raw pixels, signed Q4.12 coefficients, Q.4 output.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_color_matrix_transform (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire  [rcmt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [rcmt_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // red_sample, green_sample, blue_sample
    input  wire  [rcmt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // chan0_value, chan1_value, chan2_value, zero pad
    output logic [rcmt_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [rcmt_pkg::MODE_W-1:0] mode_reg;
    logic [rcmt_pkg::CFG_W-1:0]  row0_reg, row1_reg, row2_reg;

    logic             in_valid_reg, prod_valid_reg, out_valid_reg;
    rcmt_pkg::pixel_t pix_reg, pix_next;
    logic             adv_in, adv_prod, adv_out;

    rcmt_pkg::coef_row_t row0, row1, row2;
    rcmt_pkg::coef_row_t sel0, sel1, sel2;
    rcmt_pkg::chan_t     chan0, chan1, chan2;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rcmt_pkg::MODE_FULL;
            row0_reg <= rcmt_pkg::ROW0_RST;
            row1_reg <= rcmt_pkg::ROW1_RST;
            row2_reg <= rcmt_pkg::ROW2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rcmt_pkg::REG_MODE: mode_reg <= cfg_wdata[rcmt_pkg::MODE_W-1:0];
                rcmt_pkg::REG_ROW0: row0_reg <= cfg_wdata;
                rcmt_pkg::REG_ROW1: row1_reg <= cfg_wdata;
                rcmt_pkg::REG_ROW2: row2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign adv_out  = prod_valid_reg && (!out_valid_reg || m_tready);
    assign adv_prod = in_valid_reg && (!prod_valid_reg || adv_out);
    assign s_tready = !in_valid_reg || adv_prod;
    assign adv_in   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (adv_in) begin
                in_valid_reg <= 1'b1;
            end else if (adv_prod) begin
                in_valid_reg <= 1'b0;
            end
            if (adv_prod) begin
                prod_valid_reg <= 1'b1;
            end else if (adv_out) begin
                prod_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pix_next[k] = s_tdata[k*rcmt_pkg::SAMPLE_W +: rcmt_pkg::SAMPLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            pix_reg <= pix_next;
        end
    end

    // coefficient selection per mode
    assign row0 = rcmt_pkg::coef_row_t'(row0_reg);
    assign row1 = rcmt_pkg::coef_row_t'(row1_reg);
    assign row2 = rcmt_pkg::coef_row_t'(row2_reg);

    always_comb begin
        sel0 = '0;
        sel1 = '0;
        sel2 = '0;
        case (mode_reg)
            rcmt_pkg::MODE_MONO: begin
                sel0[0] = row0[0];
            end
            rcmt_pkg::MODE_DIAG: begin
                sel0[0] = row0[0];
                sel0[2] = row1[0];
                sel1[1] = row0[1];
                sel2[2] = row0[2];
            end
            default: begin
                sel0 = row0;
                sel1 = row1;
                sel2 = row2;
            end
        endcase
    end

    rcmt_row u_row0 (
        .aclk      (aclk),
        .prod_en   (adv_prod),
        .out_en    (adv_out),
        .coefs     (sel0),
        .pix       (pix_reg),
        .value_reg (chan0)
    );

    rcmt_row u_row1 (
        .aclk      (aclk),
        .prod_en   (adv_prod),
        .out_en    (adv_out),
        .coefs     (sel1),
        .pix       (pix_reg),
        .value_reg (chan1)
    );

    rcmt_row u_row2 (
        .aclk      (aclk),
        .prod_en   (adv_prod),
        .out_en    (adv_out),
        .coefs     (sel2),
        .pix       (pix_reg),
        .value_reg (chan2)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{rcmt_pkg::M_PAD_W{1'b0}}, chan2, chan1, chan0};

endmodule

`default_nettype wire

### sv/rcmt_checker.sv
// ----------------------------------------------------------------------------
// rcmt_checker
// Port-level checks on the color matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raw_color_matrix_transform_assert.svh"

module rcmt_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [rcmt_pkg::M_TDATA_W-1:0]   m_tdata
);

    // reset empties the pipeline
    `RCMT_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // a draining output never blocks the input side
    `RCMT_ASSERT_IMP(a_ready_follows, aclk, aresetn, m_tready, s_tready)

    // stalled word holds
    `RCMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind raw_color_matrix_transform rcmt_checker u_rcmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
